// ===== src/mf2d_pkg.sv =====
// mf2d_pkg: sizes, register map, shared types and helpers of the 2-D median filter.
// No dependencies; every other file of the block but mf2d_ram uses it by scoped names.
`default_nettype none
package mf2d_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WINDOW = 7;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 11;
	localparam int WS_W   = 3;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int RMOD_W   = $clog2(MAX_WINDOW);
	localparam int WD_W     = $clog2(MAX_WIDTH + 1);
	localparam int HT_W     = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int HALF_MAX = MAX_WINDOW / 2;
	localparam int G_W      = $clog2(HALF_MAX + 1);
	localparam int SPAN_W   = G_W + 1;
	localparam int NCELL    = MAX_WINDOW * MAX_WINDOW;
	localparam int MED_W    = $clog2(NCELL);
	localparam int RAM_DEPTH = MAX_WINDOW << COL_W;
	localparam int RAM_AW    = RMOD_W + COL_W;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);
	localparam logic [WS_W-1:0]  WS_RST     = WS_W'(3);

	// link between neighboring sort cells
	typedef struct packed {
		logic [PIX_W-1:0] val;
		logic             valid;
		logic             gt;
	} link_t;

	// position of the middle element of a (2g+1)^2 window
	function automatic logic [MED_W-1:0] med_index(input logic [G_W-1:0] g);
		int side;
		side = 2 * int'(g) + 1;
		return MED_W'((side * side) >> 1);
	endfunction
endpackage
`default_nettype wire

// ===== src/mf2d_ram.sv =====
// mf2d_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mf2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/mf2d_sort_cell.sv =====
// mf2d_sort_cell: one cell of the insertion sort chain, holds one sorted pixel.
// Depends on mf2d_pkg.
`default_nettype none
module mf2d_sort_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic                       insert,
	input  wire logic [mf2d_pkg::PIX_W-1:0] x,
	input  wire mf2d_pkg::link_t            prev,
	output mf2d_pkg::link_t                 nxt
);
	logic [mf2d_pkg::PIX_W-1:0] val_q;
	logic                       valid_q;
	logic                       gt;

	// empty cells count as larger than anything
	assign gt  = !valid_q || (val_q > x);
	assign nxt = '{val: val_q, valid: valid_q, gt: gt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (insert && gt) begin
			// shift right from the neighbor, or take the new pixel at the boundary
			valid_q <= prev.gt ? prev.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (insert && gt) begin
			val_q <= prev.gt ? prev.val : x;
		end
	end
endmodule
`default_nettype wire

// ===== src/mf2d_sort_chain.sv =====
// mf2d_sort_chain: row of sort cells kept in ascending order, plus middle select.
// Depends on mf2d_pkg and mf2d_sort_cell.
`default_nettype none
module mf2d_sort_chain (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic                       insert,
	input  wire logic [mf2d_pkg::PIX_W-1:0] x,
	input  wire logic [mf2d_pkg::MED_W-1:0] med_sel,
	output logic      [mf2d_pkg::PIX_W-1:0] median
);
	mf2d_pkg::link_t            lk   [mf2d_pkg::NCELL+1];
	logic [mf2d_pkg::PIX_W-1:0] vals [mf2d_pkg::NCELL];

	assign lk[0] = '{val: '0, valid: 1'b0, gt: 1'b0};

	for (genvar i = 0; i < mf2d_pkg::NCELL; i++) begin : g_cell
		mf2d_sort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (clear),
			.insert (insert),
			.x      (x),
			.prev   (lk[i]),
			.nxt    (lk[i+1])
		);
		assign vals[i] = lk[i+1].val;
	end

	assign median = vals[med_sel];
endmodule
`default_nettype wire

// ===== src/median_filter_2d.sv =====
// median_filter_2d: top level, register port, frame counters, line store and sweep.
// Depends on mf2d_pkg, mf2d_ram and mf2d_sort_chain.
//
// Usage:
//  - Pixels enter in raster order on the in_valid/in_ready request channel; pixel_present
//    low marks a flush request that drains the delayed tail of the frame.
//  - Results leave on out_valid/out_ready, one pixel per emitting request, with frame_end
//    high on the last pixel of the frame. Output lags input by g rows plus g pixels,
//    g = window_size/2 for an odd window, else 0 (pass-through).
//  - Sweep: an emitting request sweeps its window out of the line store one pixel a cycle
//    into the sort cell chain: the whole (2g+1)^2 window for an interior pixel, the pixel
//    alone for a border pixel. The single line store read port sets this rate. No new
//    request is taken until the sweep is through.
//  - The output register holds a finished pixel while the receiver stalls; the next
//    request is taken meanwhile, and its result waits until the register frees.
//  - Registers over APB: image_width at 0x0, image_height at 0x4, window_size at 0x8.
//    Any register write restarts the frame. Write only while the block is idle.
//  - Reset clears counters, restores register defaults and drops any pending result;
//    the line store needs no clearing.
`default_nettype none
module median_filter_2d (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mf2d_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mf2d_pkg::DATA_W-1:0] pwdata,
	output logic      [mf2d_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mf2d_pkg::PIX_W-1:0]  pixel_in,
	input  wire logic                        pixel_present,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [mf2d_pkg::PIX_W-1:0]  pixel_out,
	output logic                             frame_end
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LAST = 4'b0100,
		ST_RES  = 4'b1000
	} state_t;

	// configuration registers
	logic [mf2d_pkg::DIM_W-1:0] width_q, height_q;
	logic [mf2d_pkg::WS_W-1:0]  ws_q;

	// effective geometry
	logic [mf2d_pkg::WD_W-1:0]  w_eff;
	logic [mf2d_pkg::HT_W-1:0]  h_eff;
	logic [mf2d_pkg::G_W-1:0]   g_eff;
	logic [mf2d_pkg::CNT_W-1:0] delay, total;

	// frame position
	logic [mf2d_pkg::COL_W-1:0]  in_col_q, out_col_q;
	logic [mf2d_pkg::ROW_W-1:0]  in_row_q, out_row_q;
	logic [mf2d_pkg::RMOD_W-1:0] in_rmod_q, out_rmod_q;
	logic [mf2d_pkg::CNT_W-1:0]  in_cnt_q, out_cnt_q;
	logic                        in_done_q;

	// window sweep
	state_t                      state_q;
	logic [mf2d_pkg::G_W-1:0]    job_g_q;
	logic [mf2d_pkg::RMOD_W-1:0] cur_row_q;
	logic [mf2d_pkg::COL_W-1:0]  cur_col_q, col0_q;
	logic [mf2d_pkg::SPAN_W-1:0] ci_q, ri_q, span;
	logic                        fe_q;
	logic                        rd_vld_s1;

	logic [mf2d_pkg::PIX_W-1:0]  rdata, median;
	logic [mf2d_pkg::PIX_W-1:0]  pixel_out_q;
	logic                        frame_end_q, out_valid_q;

	logic                        cfg_we, cfg_hit;
	logic                        accept, take_px, emit_now, fin, interior;
	logic [mf2d_pkg::G_W-1:0]    jg;
	logic [mf2d_pkg::RMOD_W:0]   st_sum;
	logic [mf2d_pkg::RMOD_W-1:0] st_row;
	logic                        out_load;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		prdata  = '0;
		cfg_hit = 1'b0;
		case (paddr[3:2])
			mf2d_pkg::REG_IMAGE_WIDTH: begin
				prdata  = mf2d_pkg::DATA_W'(width_q);
				cfg_hit = 1'b1;
			end
			mf2d_pkg::REG_IMAGE_HEIGHT: begin
				prdata  = mf2d_pkg::DATA_W'(height_q);
				cfg_hit = 1'b1;
			end
			mf2d_pkg::REG_WINDOW_SIZE: begin
				prdata  = mf2d_pkg::DATA_W'(ws_q);
				cfg_hit = 1'b1;
			end
			default: begin
				prdata  = '0;
				cfg_hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf2d_pkg::WIDTH_RST;
			height_q <= mf2d_pkg::HEIGHT_RST;
			ws_q     <= mf2d_pkg::WS_RST;
		end else if (cfg_we) begin
			case (paddr[3:2])
				mf2d_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[mf2d_pkg::DIM_W-1:0];
				mf2d_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[mf2d_pkg::DIM_W-1:0];
				mf2d_pkg::REG_WINDOW_SIZE:  ws_q     <= pwdata[mf2d_pkg::WS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- effective geometry ----------------
	always_comb begin
		// clamp width and height into 1..max
		if (width_q == '0) begin
			w_eff = mf2d_pkg::WD_W'(1);
		end else if (int'(width_q) > mf2d_pkg::MAX_WIDTH) begin
			w_eff = mf2d_pkg::WD_W'(mf2d_pkg::MAX_WIDTH);
		end else begin
			w_eff = mf2d_pkg::WD_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = mf2d_pkg::HT_W'(1);
		end else if (int'(height_q) > mf2d_pkg::MAX_HEIGHT) begin
			h_eff = mf2d_pkg::HT_W'(mf2d_pkg::MAX_HEIGHT);
		end else begin
			h_eff = mf2d_pkg::HT_W'(height_q);
		end
		// even or oversized window: pass-through
		if (ws_q[0] && int'(ws_q) <= mf2d_pkg::MAX_WINDOW) begin
			g_eff = mf2d_pkg::G_W'(ws_q >> 1);
		end else begin
			g_eff = '0;
		end
		delay = mf2d_pkg::CNT_W'(g_eff) * mf2d_pkg::CNT_W'(w_eff) + mf2d_pkg::CNT_W'(g_eff);
		total = mf2d_pkg::CNT_W'(w_eff) * mf2d_pkg::CNT_W'(h_eff);
	end

	// ---------------- request decode ----------------
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign take_px  = pixel_present && !in_done_q;

	always_comb begin
		emit_now = take_px ? (in_cnt_q >= delay) : (in_done_q && (out_cnt_q < total));
		fin      = emit_now && ((out_cnt_q + mf2d_pkg::CNT_W'(1)) >= total);
		interior = (g_eff != '0)
			&& (int'(out_row_q) >= int'(g_eff)) && (int'(out_col_q) >= int'(g_eff))
			&& (int'(out_row_q) + int'(g_eff) < int'(h_eff))
			&& (int'(out_col_q) + int'(g_eff) < int'(w_eff));
		// border pixels sweep a window of one
		jg     = interior ? g_eff : '0;
		st_sum = (mf2d_pkg::RMOD_W+1)'(out_rmod_q) + (mf2d_pkg::RMOD_W+1)'(mf2d_pkg::MAX_WINDOW)
			- (mf2d_pkg::RMOD_W+1)'(jg);
		if (int'(st_sum) >= mf2d_pkg::MAX_WINDOW) begin
			st_row = mf2d_pkg::RMOD_W'(int'(st_sum) - mf2d_pkg::MAX_WINDOW);
		end else begin
			st_row = mf2d_pkg::RMOD_W'(st_sum);
		end
	end

	// ---------------- frame counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_rmod_q  <= '0;
			in_cnt_q   <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_rmod_q <= '0;
			out_cnt_q  <= '0;
		end else if ((cfg_we && cfg_hit) || (accept && fin)) begin
			// restart the frame
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_rmod_q  <= '0;
			in_cnt_q   <= '0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_rmod_q <= '0;
			out_cnt_q  <= '0;
		end else if (accept) begin
			if (take_px) begin
				in_cnt_q <= in_cnt_q + mf2d_pkg::CNT_W'(1);
				if ((mf2d_pkg::WD_W'(in_col_q) + mf2d_pkg::WD_W'(1)) >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + mf2d_pkg::ROW_W'(1);
					if (in_rmod_q == mf2d_pkg::RMOD_W'(mf2d_pkg::MAX_WINDOW - 1)) begin
						in_rmod_q <= '0;
					end else begin
						in_rmod_q <= in_rmod_q + mf2d_pkg::RMOD_W'(1);
					end
					if ((mf2d_pkg::HT_W'(in_row_q) + mf2d_pkg::HT_W'(1)) >= h_eff) begin
						in_done_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + mf2d_pkg::COL_W'(1);
				end
			end
			if (emit_now) begin
				out_cnt_q <= out_cnt_q + mf2d_pkg::CNT_W'(1);
				if ((mf2d_pkg::WD_W'(out_col_q) + mf2d_pkg::WD_W'(1)) >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + mf2d_pkg::ROW_W'(1);
					if (out_rmod_q == mf2d_pkg::RMOD_W'(mf2d_pkg::MAX_WINDOW - 1)) begin
						out_rmod_q <= '0;
					end else begin
						out_rmod_q <= out_rmod_q + mf2d_pkg::RMOD_W'(1);
					end
				end else begin
					out_col_q <= out_col_q + mf2d_pkg::COL_W'(1);
				end
			end
		end
	end

	// ---------------- line store ----------------
	mf2d_ram #(
		.WIDTH (mf2d_pkg::PIX_W),
		.DEPTH (mf2d_pkg::RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept && take_px),
		.waddr ({in_rmod_q, in_col_q}),
		.wdata (pixel_in),
		.re    (state_q == ST_READ),
		.raddr ({cur_row_q, cur_col_q}),
		.rdata (rdata)
	);

	// ---------------- window sweep ----------------
	assign span     = {job_g_q, 1'b0};
	assign out_load = (state_q == ST_RES) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (accept && emit_now) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (ci_q == span && ri_q == span) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: state_q <= ST_RES;
				ST_RES: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && emit_now) begin
			// latch the job: window start and size, last-pixel mark
			job_g_q   <= jg;
			cur_row_q <= st_row;
			cur_col_q <= out_col_q - mf2d_pkg::COL_W'(jg);
			col0_q    <= out_col_q - mf2d_pkg::COL_W'(jg);
			ci_q      <= '0;
			ri_q      <= '0;
			fe_q      <= fin;
		end else if (state_q == ST_READ) begin
			// advance raster through the window
			if (ci_q == span) begin
				ci_q      <= '0;
				cur_col_q <= col0_q;
				ri_q      <= ri_q + mf2d_pkg::SPAN_W'(1);
				if (cur_row_q == mf2d_pkg::RMOD_W'(mf2d_pkg::MAX_WINDOW - 1)) begin
					cur_row_q <= '0;
				end else begin
					cur_row_q <= cur_row_q + mf2d_pkg::RMOD_W'(1);
				end
			end else begin
				ci_q      <= ci_q + mf2d_pkg::SPAN_W'(1);
				cur_col_q <= cur_col_q + mf2d_pkg::COL_W'(1);
			end
		end
	end

	mf2d_sort_chain u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (accept && emit_now),
		.insert  (rd_vld_s1),
		.x       (rdata),
		.med_sel (mf2d_pkg::med_index(job_g_q)),
		.median  (median)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q <= median;
			frame_end_q <= fe_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

	// ---------------- assertions ----------------
	a_out_le_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= in_cnt_q)
		else $error("more results than pixels in frame");

	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_READ || state_q == ST_LAST))
		else $error("line store data outside a sweep");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RES))
		else $error("output loaded outside result state");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench of median_filter_2d (directed table, then random frames).
// Depends on mf2d_pkg and the median_filter_2d RTL; predicts untyped results in-bench.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	localparam int STALL_LIMIT = 20000;
	// quiet cycles before a register write: a full 7x7 sweep plus margin
	localparam int SWEEP_WAIT  = 80;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 925;

	typedef struct {
		logic [mf2d_pkg::PIX_W-1:0] px;
		logic                       fe;
	} pix_res_t;

	typedef enum int {ROW_CFG, ROW_PIX} row_kind_e;

	// a/b/c: width/height/window for ROW_CFG, pixel/present for ROW_PIX
	typedef struct {
		row_kind_e kind;
		int        a;
		int        b;
		int        c;
		bit        typed;
		bit        has;
		int        epx;
		bit        efe;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [mf2d_pkg::ADDR_W-1:0]   paddr;
	logic [mf2d_pkg::DATA_W-1:0]   pwdata;
	logic [mf2d_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic [mf2d_pkg::PIX_W-1:0]    pixel_in;
	logic                          pixel_present;
	logic                          out_valid;
	logic                          out_ready;
	logic [mf2d_pkg::PIX_W-1:0]    pixel_out;
	logic                          frame_end;

	median_filter_2d u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_in(pixel_in), .pixel_present(pixel_present),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .frame_end(frame_end)
	);

	// mirror of the filter: registers, line store and frame position
	logic [mf2d_pkg::DIM_W-1:0] m_width;
	logic [mf2d_pkg::DIM_W-1:0] m_height;
	logic [mf2d_pkg::WS_W-1:0]  m_wsize;
	logic [mf2d_pkg::PIX_W-1:0] m_lines [mf2d_pkg::MAX_WINDOW*mf2d_pkg::MAX_WIDTH];
	int unsigned      m_row;
	int unsigned      m_col;
	int unsigned      m_outs;
	bit               m_done;

	pix_res_t  pending_q[$];
	int        err_count;
	int        in_taken;
	int        stall_cnt;
	bit        idle_on;
	bit        hold_req;
	bit        apb_hit;

	// typed expectation that rides with the request on the wire
	bit        cur_typed;
	bit        cur_has;
	pix_res_t  cur_exp;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int unsigned frame_w();
		if (m_width == 0) return 1;
		if (m_width > mf2d_pkg::MAX_WIDTH) return mf2d_pkg::MAX_WIDTH;
		return m_width;
	endfunction

	function automatic int unsigned frame_h();
		if (m_height == 0) return 1;
		if (m_height > mf2d_pkg::MAX_HEIGHT) return mf2d_pkg::MAX_HEIGHT;
		return m_height;
	endfunction

	function automatic int unsigned half_win();
		if (m_wsize[0] == 1'b0 || m_wsize > mf2d_pkg::MAX_WINDOW) return 0;
		return m_wsize / 2;
	endfunction

	function automatic int unsigned line_addr(input int unsigned r, input int unsigned c);
		return (r % mf2d_pkg::MAX_WINDOW) * mf2d_pkg::MAX_WIDTH + (c % mf2d_pkg::MAX_WIDTH);
	endfunction

	function automatic void restart_frame();
		m_row = 0; m_col = 0; m_outs = 0; m_done = 0;
	endfunction

	// next output pixel of the frame: median inside, raw value on the border
	function automatic pix_res_t filter_next(input int unsigned w, input int unsigned h,
			input int unsigned g);
		pix_res_t                   res;
		logic [mf2d_pkg::PIX_W-1:0] win [mf2d_pkg::NCELL];
		logic [mf2d_pkg::PIX_W-1:0] x;
		int unsigned                k, r, c, n, p;
		k = m_outs;
		r = k / w;
		c = k % w;
		res.px = m_lines[line_addr(r, c)];
		if (g != 0 && r >= g && c >= g && r + g < h && c + g < w) begin
			n = 0;
			for (int unsigned i = r - g; i <= r + g; i++) begin
				for (int unsigned j = c - g; j <= c + g; j++) begin
					x = m_lines[line_addr(i, j)];
					p = n;
					while (p > 0 && win[p-1] > x) begin
						win[p] = win[p-1];
						p--;
					end
					win[p] = x;
					n++;
				end
			end
			res.px = win[n/2];
		end
		res.fe = (k + 1 == w * h);
		m_outs = k + 1;
		if (m_outs >= w * h) restart_frame();
		return res;
	endfunction

	// advance the mirror by one request; returns 1 when it yields a pixel
	function automatic bit filter_step(input logic [mf2d_pkg::PIX_W-1:0] px,
			input logic present, output pix_res_t res);
		int unsigned w, h, g, idx;
		w = frame_w();
		h = frame_h();
		g = half_win();
		if (present && !m_done) begin
			idx = m_row * w + m_col;
			m_lines[line_addr(m_row, m_col)] = px;
			m_col++;
			if (m_col >= w) begin
				m_col = 0;
				m_row++;
				if (m_row >= h) m_done = 1;
			end
			if (idx >= g * w + g) begin
				res = filter_next(w, h, g);
				return 1;
			end
			return 0;
		end
		if (m_done && m_outs < w * h) begin
			res = filter_next(w, h, g);
			return 1;
		end
		return 0;
	endfunction

	// sample both channels at the rising edge: predict on input, check on output
	always @(posedge clk) begin
		pix_res_t pred, got, want;
		bit       made;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				made = filter_step(pixel_in, pixel_present, pred);
				if (cur_typed) begin
					if (cur_has) pending_q.push_back(cur_exp);
				end else if (made) begin
					pending_q.push_back(pred);
				end
				in_taken++;
			end
			if (out_valid && out_ready) begin
				got.px = pixel_out;
				got.fe = frame_end;
				if (pending_q.size() == 0) begin
					report($sformatf("unexpected pixel %0d frame_end %0b", got.px, got.fe));
				end else begin
					want = pending_q.pop_front();
					if (got.px !== want.px)
						report($sformatf("pixel_out %0d, want %0d", got.px, want.px));
					if (got.fe !== want.fe)
						report($sformatf("frame_end %0b, want %0b", got.fe, want.fe));
				end
			end
		end
	end

	// watchdog: count cycles in which nothing moves anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || apb_hit || !arst_n)
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("median_filter_2d regression: fail");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int r;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 99) < 20) begin
				out_ready <= 1'b0;
				r = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(15, 40);
				repeat (r) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic int sender_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one request at a falling edge and hold it until taken
	task automatic send_pixel(input int px, input bit present, input bit typed,
			input bit has, input int epx, input bit efe);
		int gap, seen;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		pixel_in      <= mf2d_pkg::PIX_W'(px);
		pixel_present <= present;
		cur_typed      = typed;
		cur_has        = has;
		cur_exp.px     = mf2d_pkg::PIX_W'(epx);
		cur_exp.fe     = efe;
		seen = in_taken;
		do @(negedge clk); while (in_taken == seen);
	endtask

	// drop valid and wait until every predicted pixel has left, plus a sweep
	task automatic settle();
		in_valid <= 1'b0;
		cur_typed = 0;
		wait (pending_q.size() == 0);
		@(negedge clk);
		repeat (SWEEP_WAIT) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input int val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= mf2d_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= mf2d_pkg::DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		apb_hit  = 1;
		@(negedge clk);
		apb_hit  = 0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			mf2d_pkg::REG_IMAGE_WIDTH:  m_width  = mf2d_pkg::DIM_W'(val);
			mf2d_pkg::REG_IMAGE_HEIGHT: m_height = mf2d_pkg::DIM_W'(val);
			default:                    m_wsize  = mf2d_pkg::WS_W'(val);
		endcase
		restart_frame();
	endtask

	task automatic set_frame(input int w, input int h, input int ws);
		settle();
		apb_write(mf2d_pkg::REG_IMAGE_WIDTH, w);
		apb_write(mf2d_pkg::REG_IMAGE_HEIGHT, h);
		apb_write(mf2d_pkg::REG_WINDOW_SIZE, ws);
	endtask

	// directed table: typed rows are read straight off the spec
	stim_row_t dir_tab [] = '{
		'{ROW_PIX, 0,   1, 0, 1, 0, 0,   0},  // default 1024x1024: still filling
		'{ROW_PIX, 255, 0, 0, 1, 0, 0,   0},  // flush, nothing pending
		'{ROW_CFG, 3,   2, 1, 0, 0, 0,   0},  // window of one: pixel is its own median
		'{ROW_PIX, 0,   1, 0, 1, 1, 0,   0},
		'{ROW_PIX, 255, 1, 0, 1, 1, 255, 0},
		'{ROW_PIX, 85,  1, 0, 1, 1, 85,  0},
		'{ROW_PIX, 170, 1, 0, 1, 1, 170, 0},
		'{ROW_PIX, 1,   1, 0, 1, 1, 1,   0},
		'{ROW_PIX, 128, 1, 0, 1, 1, 128, 1},
		'{ROW_PIX, 9,   0, 0, 1, 0, 0,   0},  // flush after the frame closed
		'{ROW_CFG, 2,   1, 2, 0, 0, 0,   0},  // even window: pass-through
		'{ROW_PIX, 7,   1, 0, 1, 1, 7,   0},
		'{ROW_PIX, 200, 1, 0, 1, 1, 200, 1},
		'{ROW_CFG, 3,   3, 3, 0, 0, 0,   0},  // one interior pixel, 3x3 median
		'{ROW_PIX, 255, 1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 255, 1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 9,   1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 255, 1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 255, 1, 0, 0, 0, 0,   0},
		'{ROW_PIX, 33,  1, 0, 0, 0, 0,   0},  // real pixel during drain: discarded
		'{ROW_PIX, 0,   0, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   0, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   0, 0, 0, 0, 0,   0},
		'{ROW_PIX, 0,   0, 0, 1, 0, 0,   0}   // tail drained: nothing left
	};

	initial begin
		int  sent, w, h, ws, total, lag, n, pick, half;
		bit  first, full;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		pixel_in      = '0;
		pixel_present = 1'b0;
		err_count     = 0;
		in_taken      = 0;
		stall_cnt     = 0;
		idle_on       = 1;
		hold_req      = 0;
		apb_hit       = 0;
		cur_typed     = 0;
		m_width       = mf2d_pkg::DIM_W'(mf2d_pkg::MAX_WIDTH);
		m_height      = mf2d_pkg::DIM_W'(mf2d_pkg::MAX_HEIGHT);
		m_wsize       = mf2d_pkg::WS_W'(3);
		restart_frame();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				set_frame(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c);
			else
				send_pixel(dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed,
					dir_tab[i].has, dir_tab[i].epx, dir_tab[i].efe);
		end

		// random frames; the first is large, stalls the output and pauses the sender
		sent  = 0;
		first = 1;
		while (sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			full = 1;
			if (first) begin
				w = 12; h = 10; ws = 5;
			end else if (pick < 10) begin
				// register extremes: out-of-range sizes and a bare frame start
				w  = ($urandom_range(0, 1)) ? 2047 : $urandom_range(0, 1);
				h  = ($urandom_range(0, 1)) ? 2047 : 0;
				ws = $urandom_range(0, 7);
				full = 0;
			end else begin
				w  = $urandom_range(1, 12);
				h  = $urandom_range(1, 10);
				ws = $urandom_range(0, 7);
				full = (pick >= 30);
			end
			set_frame(w, h, ws);
			idle_on = first ? 1 : ($urandom_range(0, 3) != 0);
			if (first) hold_req = 1;
			w     = frame_w();
			h     = frame_h();
			total = w * h;
			lag   = half_win() * w + half_win();
			lag   = (lag < total) ? lag : total;
			n     = full ? total : $urandom_range(1, (total < 40) ? total : 40);
			half  = n / 2;
			for (int i = 0; i < n; i++) begin
				if (first && i == half) begin
					// pause the sender until the output catches up
					in_valid <= 1'b0;
					wait (pending_q.size() == 0);
					@(negedge clk);
				end
				// noise: a flush tick mid-frame yields nothing
				if ($urandom_range(0, 9) == 0) begin
					send_pixel(0, 0, 0, 0, 0, 0);
					sent++;
				end
				send_pixel($urandom_range(0, 255), 1, 0, 0, 0, 0);
				sent++;
			end
			if (full) begin
				// drain the tail: flush ticks, some disguised as pixels
				for (int i = 0; i < lag + $urandom_range(0, 1); i++) begin
					send_pixel($urandom_range(0, 255), $urandom_range(0, 9) < 3, 0, 0, 0, 0);
					sent++;
				end
			end
			first = 0;
		end

		settle();
		if (err_count == 0) begin
			$display("median_filter_2d regression: pass");
		end else begin
			$display("median_filter_2d regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
src/mf2d_pkg.sv
src/mf2d_ram.sv
src/mf2d_sort_cell.sv
src/mf2d_sort_chain.sv
src/median_filter_2d.sv
verif/tb.sv
